// ===== sv/ppm_pkg.sv =====
// Shared types, widths and constants for the parabolic edge reconstruction pipeline.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package ppm_pkg;

  // Sample format and derived internal widths.
  localparam int SAMPLE_W    = 32;
  localparam int DIFF_W      = SAMPLE_W + 1;  // neighbor difference, doubled slope
  localparam int MAG_W       = SAMPLE_W + 3;  // four times a slope magnitude
  localparam int NUM_W       = SAMPLE_W + 5;  // interface numerator
  localparam int EXT_W       = SAMPLE_W + 1;  // extremum edge
  localparam int EXT_NUM_W   = SAMPLE_W + 3;  // extremum edge numerator
  localparam int DIV_W       = SAMPLE_W + 4;  // offset dividend of the divide by three
  localparam int DIV_HALF    = (DIV_W + 1) / 2;
  localparam int PP_W        = 2 * DIV_HALF;
  localparam int PROD_W      = 2 * DIV_W;
  localparam int DIV_SHIFT   = DIV_W + 1;
  localparam int QUOT_W      = SAMPLE_W + 4;  // interface value before correction
  localparam int DLT_W       = SAMPLE_W + 5;  // edge minus cell value
  localparam int CAND_W      = SAMPLE_W + 7;  // corrected edge before saturation

  // Window fill count.
  localparam int FILL_W = 3;
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(4);

  // Reciprocal of three: ceil(2^DIV_SHIFT / 3), exact for every DIV_W-bit dividend.
  localparam logic [DIV_W-1:0] DIV_MUL = DIV_W'(((64'd1 << DIV_SHIFT) + 64'd2) / 64'd3);
  // Offset that makes the dividend non-negative; it is a multiple of three.
  localparam logic signed [NUM_W-1:0]  DIV_OFS = NUM_W'(3) <<< (SAMPLE_W + 1);
  // The offset divided by three, removed again from the quotient.
  localparam logic signed [QUOT_W-1:0] Q_OFS   = QUOT_W'(1) <<< (SAMPLE_W + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [DIFF_W-1:0]   diff_t;
  typedef logic signed [QUOT_W-1:0]   quot_t;
  typedef logic signed [EXT_W-1:0]    ext_t;

  // Kind of monotonicity correction applied to a result.
  typedef enum logic [2:0] {
    CORR_NONE     = 3'd0,
    CORR_EXTREMUM = 3'd1,
    CORR_LEFT     = 3'd2,
    CORR_RIGHT    = 3'd3,
    CORR_BOTH     = 3'd4
  } corr_e;

  // Window snapshot with neighbor differences.
  typedef struct packed {
    sample_t s1;
    sample_t s2;
    sample_t s3;
    diff_t   d10;
    diff_t   d21;
    diff_t   d32;
    diff_t   d43;
  } win_t;

  // Centre cells with their doubled limited slopes.
  typedef struct packed {
    sample_t s1;
    sample_t s2;
    sample_t s3;
    diff_t   m1;
    diff_t   m2;
    diff_t   m3;
  } slp_t;

  // Uncorrected interfaces and extremum edges of the centre cell.
  typedef struct packed {
    sample_t s2;
    quot_t   am;
    quot_t   ap;
    ext_t    el;
    ext_t    er;
  } edge_t;

endpackage

`default_nettype wire

// ===== sv/ppm_interface_reconstruction.sv =====
// Top level of the parabolic edge reconstruction: stream ports and the stage chain.
// Depends on ppm_pkg, ppm_window, ppm_slope, ppm_iface and ppm_limit.
`default_nettype none

// One signed Q15.16 cell average enters per cycle on the slave stream
// while s_axis_tready is high; the tuser bit marks the first sample of a
// line. From the fifth sample of a line on, every sample yields one result
// on the master stream: the left and right edge values of the cell two
// places back, after monotonicity correction and saturation, with the
// correction kind in tuser. The first four samples of each line yield no
// result. Throughput is one transaction per cycle while m_axis_tready
// holds, set by a seven-stage pipeline (window, slope limiter, interface
// numerator, reciprocal partial products, quotient, edge differences,
// correction) whose stages each hold an item and advance independently, so
// empty stages fill while a finished result waits on tready.
module ppm_interface_reconstruction import ppm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [SAMPLE_W-1:0]   s_axis_tdata,  // [31:0] sample
  input  logic                  s_axis_tuser,  // [0] line_start
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [2*SAMPLE_W-1:0] m_axis_tdata,  // [31:0] left_edge, [63:32] right_edge
  output logic [2:0]            m_axis_tuser   // [2:0] correction
);

  logic    win_valid, win_ready;
  win_t    win;
  logic    slp_valid, slp_ready;
  slp_t    slp;
  logic    edg_valid, edg_ready;
  edge_t   edg;
  sample_t left_edge, right_edge;
  corr_e   correction;

  ppm_window u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .sample_i     (s_axis_tdata),
    .line_start_i (s_axis_tuser),
    .valid_o      (win_valid),
    .ready_i      (win_ready),
    .win_o        (win)
  );

  ppm_slope u_slope (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (win_valid),
    .ready_o (win_ready),
    .win_i   (win),
    .valid_o (slp_valid),
    .ready_i (slp_ready),
    .slp_o   (slp)
  );

  ppm_iface u_iface (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (slp_valid),
    .ready_o (slp_ready),
    .slp_i   (slp),
    .valid_o (edg_valid),
    .ready_i (edg_ready),
    .edge_o  (edg)
  );

  ppm_limit u_limit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (edg_valid),
    .ready_o      (edg_ready),
    .edge_i       (edg),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .left_edge_o  (left_edge),
    .right_edge_o (right_edge),
    .correction_o (correction)
  );

  // Output packing: left edge in the low word.
  assign m_axis_tdata = {right_edge, left_edge};
  assign m_axis_tuser = correction;

endmodule

`default_nettype wire

// ===== sv/ppm_window.sv =====
// Input stage: four-sample shift window, line fill count and neighbor differences.
// Depends on ppm_pkg.
`default_nettype none

module ppm_window import ppm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  sample_t sample_i,
  input  logic    line_start_i,
  output logic    valid_o,
  input  logic    ready_i,
  output win_t    win_o
);

  sample_t           win_q [4];
  logic [FILL_W-1:0] fill_q, fill_d, fill_eff;
  logic              full;
  logic              accept;
  logic              valid_q, valid_d;
  win_t              out_q, out_d;

  assign ready_o = !valid_q || ready_i;
  assign accept  = valid_i && ready_o;

  // A line start restarts the count; four held samples and the accepted one give a result.
  always_comb begin
    fill_eff = line_start_i ? '0 : fill_q;
    full     = (fill_eff >= FILL_FULL);
    fill_d   = fill_q;
    if (accept) begin
      fill_d = full ? fill_eff : fill_eff + FILL_W'(1);
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = accept && full;
    end
  end

  // Snapshot of the centre cells and the four neighbor differences.
  always_comb begin
    out_d.s1  = win_q[1];
    out_d.s2  = win_q[2];
    out_d.s3  = win_q[3];
    out_d.d10 = DIFF_W'(win_q[1]) - DIFF_W'(win_q[0]);
    out_d.d21 = DIFF_W'(win_q[2]) - DIFF_W'(win_q[1]);
    out_d.d32 = DIFF_W'(win_q[3]) - DIFF_W'(win_q[2]);
    out_d.d43 = DIFF_W'(sample_i) - DIFF_W'(win_q[3]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      valid_q <= valid_d;
    end
  end

  // Window shift and stage payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= win_q[3];
      win_q[3] <= sample_i;
      out_q    <= out_d;
    end
  end

  assign valid_o = valid_q;
  assign win_o   = out_q;

endmodule

`default_nettype wire

// ===== sv/ppm_slope.sv =====
// Slope stage: doubled monotonized-central limited slopes of the three centre cells.
// Depends on ppm_pkg.
`default_nettype none

module ppm_slope import ppm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  win_t win_i,
  output logic valid_o,
  input  logic ready_i,
  output slp_t slp_o
);

  logic valid_q;
  slp_t out_q, out_d;

  // Doubled limited slope: zero unless both differences share a sign,
  // else the smallest of four times each difference and their sum.
  function automatic diff_t mc2(input diff_t a, input diff_t b);
    logic [DIFF_W-1:0]     abs_a;
    logic [DIFF_W-1:0]     abs_b;
    logic signed [DIFF_W:0] sum;
    logic [MAG_W-1:0]      a4;
    logic [MAG_W-1:0]      b4;
    logic [MAG_W-1:0]      sab;
    logic [MAG_W-1:0]      m;
    diff_t                 r;
    abs_a = a[DIFF_W-1] ? -a : a;
    abs_b = b[DIFF_W-1] ? -b : b;
    sum   = (DIFF_W + 1)'(a) + (DIFF_W + 1)'(b);
    a4    = {abs_a, 2'b00};
    b4    = {abs_b, 2'b00};
    sab   = MAG_W'(sum[DIFF_W] ? -sum : sum);
    m     = (b4 < a4) ? b4 : a4;
    if (sab < m) begin
      m = sab;
    end
    if (a == '0 || b == '0 || a[DIFF_W-1] != b[DIFF_W-1]) begin
      r = '0;
    end else if (a[DIFF_W-1]) begin
      r = -DIFF_W'(m);
    end else begin
      r = DIFF_W'(m);
    end
    return r;
  endfunction

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    out_d.s1 = win_i.s1;
    out_d.s2 = win_i.s2;
    out_d.s3 = win_i.s3;
    out_d.m1 = mc2(win_i.d21, win_i.d10);
    out_d.m2 = mc2(win_i.d32, win_i.d21);
    out_d.m3 = mc2(win_i.d43, win_i.d32);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      out_q <= out_d;
    end
  end

  assign valid_o = valid_q;
  assign slp_o   = out_q;

endmodule

`default_nettype wire

// ===== sv/ppm_iface.sv =====
// Interface stages: parabola interfaces with a pipelined divide by twelve,
// plus the extremum edges. Depends on ppm_pkg.
`default_nettype none

module ppm_iface import ppm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  slp_t  slp_i,
  output logic  valid_o,
  input  logic  ready_i,
  output edge_t edge_o
);

  // Stage A: offset dividends and extremum edges.
  logic             va_q, ra;
  logic [DIV_W-1:0] ul_q, ur_q, ul_d, ur_d;
  sample_t          s2a_q;
  ext_t             ela_q, era_q, el_d, er_d;
  // Stage B: partial products of the reciprocal multiply.
  logic             vb_q, rb;
  logic [PP_W-1:0]  ppl_q [4];
  logic [PP_W-1:0]  ppr_q [4];
  sample_t          s2b_q;
  ext_t             elb_q, erb_q;
  // Stage C: quotients.
  logic             vc_q, rc;
  edge_t            out_q, out_d;

  // Interface numerator 6x + 6y + ml - mr + 6, floored by four and
  // shifted to a non-negative dividend for the divide by three.
  function automatic logic [DIV_W-1:0] dividend(input sample_t x, input sample_t y,
                                                input diff_t ml, input diff_t mr);
    logic signed [NUM_W-1:0] sum;
    logic signed [NUM_W-1:0] num;
    logic signed [NUM_W-1:0] sh;
    sum = NUM_W'(x) + NUM_W'(y);
    num = (sum <<< 2) + (sum <<< 1) + NUM_W'(ml) - NUM_W'(mr) + NUM_W'(6);
    sh  = (num >>> 2) + DIV_OFS;
    return sh[DIV_W-1:0];
  endfunction

  // Extremum edge (4 s2 + m + 2) / 4, floored.
  function automatic ext_t ext_edge(input sample_t s, input diff_t m);
    logic signed [EXT_NUM_W-1:0] t;
    t = (EXT_NUM_W'(s) <<< 2) + EXT_NUM_W'(m) + EXT_NUM_W'(2);
    return t[EXT_NUM_W-1:2];
  endfunction

  // Quotient from the partial products, offset removed.
  function automatic quot_t quotient(input logic [PP_W-1:0] hh, input logic [PP_W-1:0] hl,
                                     input logic [PP_W-1:0] lh, input logic [PP_W-1:0] ll);
    logic [PROD_W-1:0]           prod;
    logic [PROD_W-DIV_SHIFT-1:0] q;
    prod = (PROD_W'(hh) << (2 * DIV_HALF)) + (PROD_W'(hl) << DIV_HALF)
         + (PROD_W'(lh) << DIV_HALF) + PROD_W'(ll);
    q    = prod[PROD_W-1:DIV_SHIFT];
    return $signed(QUOT_W'(q)) - Q_OFS;
  endfunction

  assign rc      = !vc_q || ready_i;
  assign rb      = !vb_q || rc;
  assign ra      = !va_q || rb;
  assign ready_o = ra;

  always_comb begin
    ul_d = dividend(slp_i.s1, slp_i.s2, slp_i.m1, slp_i.m2);
    ur_d = dividend(slp_i.s2, slp_i.s3, slp_i.m2, slp_i.m3);
    el_d = ext_edge(slp_i.s2, -slp_i.m2);
    er_d = ext_edge(slp_i.s2, slp_i.m2);
  end

  always_comb begin
    out_d.s2 = s2b_q;
    out_d.el = elb_q;
    out_d.er = erb_q;
    out_d.am = quotient(ppl_q[0], ppl_q[1], ppl_q[2], ppl_q[3]);
    out_d.ap = quotient(ppr_q[0], ppr_q[1], ppr_q[2], ppr_q[3]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (ra) begin
        va_q <= valid_i;
      end
      if (rb) begin
        vb_q <= va_q;
      end
      if (rc) begin
        vc_q <= vb_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ra && valid_i) begin
      ul_q  <= ul_d;
      ur_q  <= ur_d;
      s2a_q <= slp_i.s2;
      ela_q <= el_d;
      era_q <= er_d;
    end
    if (rb && va_q) begin
      ppl_q[0] <= ul_q[DIV_W-1:DIV_HALF] * DIV_MUL[DIV_W-1:DIV_HALF];
      ppl_q[1] <= ul_q[DIV_W-1:DIV_HALF] * DIV_MUL[DIV_HALF-1:0];
      ppl_q[2] <= ul_q[DIV_HALF-1:0] * DIV_MUL[DIV_W-1:DIV_HALF];
      ppl_q[3] <= ul_q[DIV_HALF-1:0] * DIV_MUL[DIV_HALF-1:0];
      ppr_q[0] <= ur_q[DIV_W-1:DIV_HALF] * DIV_MUL[DIV_W-1:DIV_HALF];
      ppr_q[1] <= ur_q[DIV_W-1:DIV_HALF] * DIV_MUL[DIV_HALF-1:0];
      ppr_q[2] <= ur_q[DIV_HALF-1:0] * DIV_MUL[DIV_W-1:DIV_HALF];
      ppr_q[3] <= ur_q[DIV_HALF-1:0] * DIV_MUL[DIV_HALF-1:0];
      s2b_q    <= s2a_q;
      elb_q    <= ela_q;
      erb_q    <= era_q;
    end
    if (rc && vb_q) begin
      out_q <= out_d;
    end
  end

  assign valid_o = vc_q;
  assign edge_o  = out_q;

endmodule

`default_nettype wire

// ===== sv/ppm_limit.sv =====
// Correction stages: monotonicity test, edge reset or flattening, saturation
// and the output register. Depends on ppm_pkg.
`default_nettype none

module ppm_limit import ppm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  edge_t   edge_i,
  output logic    valid_o,
  input  logic    ready_i,
  output sample_t left_edge_o,
  output sample_t right_edge_o,
  output corr_e   correction_o
);

  localparam logic signed [CAND_W-1:0] SAT_HI = CAND_W'({1'b0, {(SAMPLE_W - 1){1'b1}}});
  localparam logic signed [CAND_W-1:0] SAT_LO = -SAT_HI - CAND_W'(1);

  typedef logic signed [DLT_W-1:0]  dlt_t;
  typedef logic signed [CAND_W-1:0] cand_t;

  // Stage D: edge differences.
  logic    vd_q, rd;
  dlt_t    dm_q, dp_q;
  edge_t   ed_q;
  // Stage E: output register.
  logic    ve_q, re;
  sample_t left_q, right_q, left_d, right_d;
  corr_e   code_q, code_d;

  function automatic sample_t sat(input cand_t x);
    cand_t y;
    y = x;
    if (x > SAT_HI) begin
      y = SAT_HI;
    end else if (x < SAT_LO) begin
      y = SAT_LO;
    end
    return y[SAMPLE_W-1:0];
  endfunction

  assign re      = !ve_q || ready_i;
  assign rd      = !vd_q || re;
  assign ready_o = rd;

  // Extremum replaces the pair with the extremum edges; otherwise an edge that overshoots is reset.
  always_comb begin
    logic           extremum;
    logic [DLT_W-1:0] adm;
    logic [DLT_W-1:0] adp;
    logic           lreset;
    logic           rreset;
    cand_t          lcand;
    cand_t          rcand;
    extremum = (dm_q == '0) || (dp_q == '0) || (dm_q[DLT_W-1] != dp_q[DLT_W-1]);
    adm      = dm_q[DLT_W-1] ? -dm_q : dm_q;
    adp      = dp_q[DLT_W-1] ? -dp_q : dp_q;
    lreset   = {1'b0, adm} >= {adp, 1'b0};
    rreset   = {1'b0, adp} >= {adm, 1'b0};
    lcand    = CAND_W'(ed_q.am);
    rcand    = CAND_W'(ed_q.ap);
    code_d   = CORR_NONE;
    if (extremum) begin
      lcand  = CAND_W'(ed_q.el);
      rcand  = CAND_W'(ed_q.er);
      code_d = CORR_EXTREMUM;
    end else begin
      if (lreset) begin
        lcand = CAND_W'(ed_q.s2) - (CAND_W'(dp_q) <<< 1);
      end
      if (rreset) begin
        rcand = CAND_W'(ed_q.s2) + (CAND_W'(dm_q) <<< 1);
      end
      if (lreset && rreset) begin
        code_d = CORR_BOTH;
      end else if (lreset) begin
        code_d = CORR_LEFT;
      end else if (rreset) begin
        code_d = CORR_RIGHT;
      end
    end
    left_d  = sat(lcand);
    right_d = sat(rcand);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      if (rd) begin
        vd_q <= valid_i;
      end
      if (re) begin
        ve_q <= vd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd && valid_i) begin
      dm_q <= DLT_W'(edge_i.s2) - DLT_W'(edge_i.am);
      dp_q <= DLT_W'(edge_i.ap) - DLT_W'(edge_i.s2);
      ed_q <= edge_i;
    end
    if (re && vd_q) begin
      left_q  <= left_d;
      right_q <= right_d;
      code_q  <= code_d;
    end
  end

  assign valid_o      = ve_q;
  assign left_edge_o  = left_q;
  assign right_edge_o = right_q;
  assign correction_o = code_q;

endmodule

`default_nettype wire
